@@ sv/tgr_pkg.sv @@
// Shared types, codes and widths of the touch gesture recogniser.
package tgr_pkg;

    localparam int unsigned SQ_W    = 34;
    localparam int unsigned SPAN_W  = 17;
    localparam int unsigned ACCUM_W = 18;
    localparam int unsigned IN_W    = 80;
    localparam int unsigned OUT_W   = 104;
    localparam int unsigned RES_MAX = 3;

    localparam int unsigned DEF_MAX_TOUCHES = 8;
    localparam int unsigned DEF_ID_BITS     = 8;

    localparam logic [15:0] RST_LONG_MS  = 16'd500;
    localparam logic [15:0] RST_TAP_MS   = 16'd300;
    localparam logic [11:0] RST_MOVE_PX  = 12'd32;
    localparam logic [11:0] RST_PINCH_PX = 12'd35;

    localparam logic [1:0] CFG_LONG_MS  = 2'd0;
    localparam logic [1:0] CFG_TAP_MS   = 2'd1;
    localparam logic [1:0] CFG_MOVE_PX  = 2'd2;
    localparam logic [1:0] CFG_PINCH_PX = 2'd3;

    localparam logic [2:0] OP_DOWN   = 3'd0;
    localparam logic [2:0] OP_MOVE   = 3'd1;
    localparam logic [2:0] OP_UP     = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [2:0] K_NONE    = 3'd0;
    localparam logic [2:0] K_TAP_UP  = 3'd1;
    localparam logic [2:0] K_TAP_OK  = 3'd2;
    localparam logic [2:0] K_LONG    = 3'd3;
    localparam logic [2:0] K_DOUBLE  = 3'd4;
    localparam logic [2:0] K_P_START = 3'd5;
    localparam logic [2:0] K_P_SCALE = 3'd6;
    localparam logic [2:0] K_P_END   = 3'd7;

    typedef enum logic [4:0] {
        M_NONE    = 5'b00001,
        M_WSINGLE = 5'b00010,
        M_WDOUBLE = 5'b00100,
        M_WPINCH  = 5'b01000,
        M_PINCH   = 5'b10000
    } t_mode;

    typedef struct packed {
        logic                  consumed;
        logic [SPAN_W-1:0]     span_before;
        logic [SPAN_W-1:0]     span_now;
        logic signed [15:0]    point_y;
        logic signed [15:0]    point_x;
        logic [31:0]           event_time;
        logic [2:0]            gesture_kind;
    } t_res;

    function automatic t_res make_res(input logic [2:0] kind, input logic [31:0] t,
                                      input logic [15:0] x, input logic [15:0] y,
                                      input logic [SPAN_W-1:0] sn,
                                      input logic [SPAN_W-1:0] sb, input logic c);
        t_res r;
        r.gesture_kind = kind;
        r.event_time   = t;
        r.point_x      = x;
        r.point_y      = y;
        r.span_now     = sn;
        r.span_before  = sb;
        r.consumed     = c;
        return r;
    endfunction

endpackage

@@ sv/tgr_isqrt.sv @@
// Bit-serial integer square root, one result bit per cycle.
module tgr_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tgr_pkg::SQ_W-1:0]  i_value,
    output logic                      o_done,
    output logic [tgr_pkg::SPAN_W-1:0] o_root
);
    import tgr_pkg::*;

    localparam int unsigned REM_W = SPAN_W + 2;
    localparam int unsigned CNT_W = $clog2(SPAN_W + 1);

    logic [SQ_W-1:0]   r_v;
    logic [REM_W-1:0]  r_rem;
    logic [SPAN_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [REM_W-1:0]  w_rem;
    logic [REM_W-1:0]  w_trial;

    assign w_rem   = {r_rem[REM_W-3:0], r_v[SQ_W-1:SQ_W-2]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SPAN_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_v <= {r_v[SQ_W-3:0], 2'b00};
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[SPAN_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[SPAN_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ sv/touch_gesture_recognizer_top.sv @@
// Top level of the touch gesture recogniser: sequencer, touch table and result buffer.
//
// One touch event enters per slave beat (op, touch_id, pos_x, pos_y, time_ms).
// Each event yields zero to three result beats on the master side; tlast marks
// the final beat of an event. Configuration registers (index 0 long tap delay,
// 1 tap max, 2 move tolerance, 3 pinch start distance): the user writes them through
// the plain write port only while no event is in flight; the block does not enforce it.
// Timing: an event is held for processing while o_s_axis_tready is low. A tick
// or an unknown op passes through S_DECODE only; up, down and cancel with fewer
// than two touches go through S_DECODE, S_TOUCH and S_PSET; with two or more
// touches the squared distance is built in S_MULX and S_MULY on one multiplier
// and rooted by the bit-serial root unit; a move adds a second distance and root pass.
// Result beats then follow one per cycle as the receiver accepts them.
// A stalled receiver holds the current result beat and blocks new events.
// Reset is synchronous and active low: the table empties, timers disarm,
// the registers return to 500, 300, 32 and 35.
module touch_gesture_recognizer_top #(
    parameter int unsigned MAX_TOUCHES = tgr_pkg::DEF_MAX_TOUCHES,
    parameter int unsigned ID_BITS     = tgr_pkg::DEF_ID_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // op[2:0], touch_id[10:3], pos_x[26:11], pos_y[42:27], time_ms[74:43], zero pad
    input  logic [tgr_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // gesture_kind[2:0], event_time[34:3], point_x[50:35], point_y[66:51],
    // span_now[83:67], span_before[100:84], consumed[101], zero pad
    output logic [tgr_pkg::OUT_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tlast,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [15:0]                i_cfg_data
);
    import tgr_pkg::*;

    localparam int unsigned CW = $clog2(MAX_TOUCHES + 1);
    localparam int unsigned IW = $clog2(MAX_TOUCHES);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_MULX   = 9'b000000100,
        S_MULY   = 9'b000001000,
        S_ROOT   = 9'b000010000,
        S_TOUCH  = 9'b000100000,
        S_PSET   = 9'b001000000,
        S_PINCH  = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_long_ms, r_tap_ms;
    logic [11:0] r_move_px, r_pinch_px;

    logic [ID_BITS-1:0] r_slot_id [MAX_TOUCHES];
    logic [15:0]        r_slot_x  [MAX_TOUCHES];
    logic [15:0]        r_slot_y  [MAX_TOUCHES];
    logic [ID_BITS-1:0] n_slot_id [MAX_TOUCHES];
    logic [15:0]        n_slot_x  [MAX_TOUCHES];
    logic [15:0]        n_slot_y  [MAX_TOUCHES];
    logic [CW-1:0]      r_count, n_count;

    t_mode               r_mode, n_mode;
    logic [ACCUM_W-1:0]  r_accum, n_accum;
    logic [SPAN_W-1:0]   r_sprev, n_sprev;
    logic [31:0]         r_tbegin, n_tbegin, r_tfinish, n_tfinish;
    logic [15:0]         r_spx, n_spx, r_spy, n_spy;
    logic [31:0]         r_ldl, n_ldl, r_ddl, n_ddl;
    logic                r_larm, n_larm, r_darm, n_darm;
    logic [15:0]         r_rx, n_rx, r_ry, n_ry;
    logic [31:0]         r_rt, n_rt;

    logic [2:0]          r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [15:0]         r_x, r_y;
    logic [31:0]         r_t;
    logic signed [16:0]  r_dx, n_dx, r_dy, n_dy;
    logic [15:0]         r_fx, n_fx, r_fy, n_fy;
    logic [SQ_W-1:0]     r_acc, n_acc;
    logic                r_phase, n_phase;
    t_res                r_res [RES_MAX];
    t_res                n_res [RES_MAX];
    logic [1:0]          r_nres, n_nres, r_oidx, n_oidx;

    logic                w_in_acc, w_out_acc;
    logic signed [16:0]  w_mop;
    logic signed [33:0]  w_sq;
    logic [SQ_W-1:0]     w_acc_sum;
    logic                w_root_start, w_root_done;
    logic [SPAN_W-1:0]   w_root;
    logic [CW-1:0]       w_cm1;
    logic [ID_BITS-1:0]  w_in_id;
    logic [23:0]         w_tol2;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_in_id   = ID_BITS'({{ID_BITS{1'b0}}, i_s_axis_tdata[10:3]});

    assign w_mop        = (r_state == S_MULX) ? r_dx : r_dy;
    assign w_sq         = w_mop * w_mop;
    assign w_acc_sum    = r_acc + SQ_W'(unsigned'(w_sq));
    assign w_root_start = (r_state == S_MULY);
    assign w_cm1        = r_count - CW'(1);
    assign w_tol2       = {12'd0, r_move_px} * {12'd0, r_move_px};

    tgr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (w_acc_sum),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    always_comb begin
        logic [1:0]          k;
        logic                found;
        logic [IW-1:0]       pos;
        logic [CW-1:0]       cnt;
        logic [31:0]         dt;
        logic [SPAN_W-1:0]   d;
        logic [ACCUM_W:0]    sum;
        logic                shown;
        logic signed [16:0]  s;
        logic [15:0]         lx, ly;

        n_state   = r_state;
        n_slot_id = r_slot_id;
        n_slot_x  = r_slot_x;
        n_slot_y  = r_slot_y;
        n_count   = r_count;
        n_mode    = r_mode;
        n_accum   = r_accum;
        n_sprev   = r_sprev;
        n_tbegin  = r_tbegin;
        n_tfinish = r_tfinish;
        n_spx     = r_spx;
        n_spy     = r_spy;
        n_ldl     = r_ldl;
        n_ddl     = r_ddl;
        n_larm    = r_larm;
        n_darm    = r_darm;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_rt      = r_rt;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_fx      = r_fx;
        n_fy      = r_fy;
        n_acc     = r_acc;
        n_phase   = r_phase;
        n_res     = r_res;
        n_nres    = r_nres;
        n_oidx    = r_oidx;
        k         = r_nres;
        found     = 1'b0;
        pos       = '0;
        cnt       = r_count;
        dt        = '0;
        d         = '0;
        sum       = '0;
        shown     = 1'b0;
        s         = '0;
        lx        = r_slot_x[w_cm1[IW-1:0]];
        ly        = r_slot_y[w_cm1[IW-1:0]];

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_nres  = '0;
                    n_oidx  = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (r_op == OP_TICK) begin
                    dt = r_t - r_ldl;
                    if (r_larm && !dt[31]) begin
                        n_larm = 1'b0;
                        if (r_mode == M_WSINGLE) begin
                            n_mode = M_NONE;
                            n_res[k] = make_res(K_LONG, r_rt, r_rx, r_ry, '0, '0, 1'b0);
                            k = k + 2'd1;
                        end
                    end
                    dt = r_t - r_ddl;
                    if (r_darm && !dt[31]) begin
                        n_darm = 1'b0;
                        if (r_mode == M_WDOUBLE) begin
                            n_mode = M_NONE;
                            n_res[k] = make_res(K_TAP_OK, r_rt, r_rx, r_ry, '0, '0, 1'b0);
                            k = k + 2'd1;
                        end
                    end
                    n_state = (k != 2'd0) ? S_OUT : S_IDLE;
                end else if (r_op == OP_MOVE) begin
                    n_dx    = $signed({r_spx[15], r_spx}) - $signed({r_x[15], r_x});
                    n_dy    = $signed({r_spy[15], r_spy}) - $signed({r_y[15], r_y});
                    n_phase = 1'b0;
                    n_state = S_MULX;
                end else if (r_op > OP_TICK) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_TOUCH;
                end
            end
            S_MULX: begin
                n_acc   = SQ_W'(unsigned'(w_sq));
                n_state = S_MULY;
            end
            S_MULY: begin
                n_acc   = w_acc_sum;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_done) n_state = r_phase ? S_PINCH : S_TOUCH;
            end
            S_TOUCH: begin
                n_rx = r_x;
                n_ry = r_y;
                n_rt = r_t;
                case (r_op)
                    OP_DOWN: begin
                        for (int i = 0; i < MAX_TOUCHES; i++) begin
                            if (CW'(i) < r_count && r_slot_id[i] == r_id) found = 1'b1;
                        end
                        if (!found && r_count < CW'(MAX_TOUCHES)) begin
                            n_slot_id[r_count[IW-1:0]] = r_id;
                            n_slot_x[r_count[IW-1:0]]  = r_x;
                            n_slot_y[r_count[IW-1:0]]  = r_y;
                            cnt = r_count + CW'(1);
                        end
                        n_count = cnt;
                        if (cnt == CW'(1)) begin
                            n_tbegin = r_t;
                            n_spx    = r_x;
                            n_spy    = r_y;
                            if (r_mode == M_NONE) begin
                                n_mode = M_WSINGLE;
                                n_ldl  = r_t + 32'(r_long_ms);
                                n_larm = 1'b1;
                            end
                        end else if (cnt == CW'(2)) begin
                            n_tbegin = '0;
                            if (r_mode == M_WSINGLE) begin
                                n_larm = 1'b0;
                                n_mode = M_NONE;
                            end else if (r_mode == M_WDOUBLE) begin
                                n_mode = M_NONE;
                            end
                        end
                    end
                    OP_MOVE: begin
                        if (r_count == CW'(1) && r_acc > SQ_W'(w_tol2)) begin
                            n_tbegin = '0;
                            if (r_mode == M_WSINGLE) begin
                                n_larm = 1'b0;
                                n_mode = M_NONE;
                            end else if (r_mode == M_WDOUBLE) begin
                                n_mode = M_NONE;
                            end
                        end
                        for (int i = 0; i < MAX_TOUCHES; i++) begin
                            if (CW'(i) < r_count && r_slot_id[i] == r_id) begin
                                n_slot_x[i] = r_x;
                                n_slot_y[i] = r_y;
                            end
                        end
                    end
                    OP_UP: begin
                        for (int i = MAX_TOUCHES - 1; i >= 0; i--) begin
                            if (CW'(i) < r_count && r_slot_id[i] == r_id) begin
                                found = 1'b1;
                                pos   = IW'(i);
                            end
                        end
                        if (found) begin
                            for (int j = 0; j < MAX_TOUCHES - 1; j++) begin
                                if (IW'(j) >= pos) begin
                                    n_slot_id[j] = r_slot_id[j+1];
                                    n_slot_x[j]  = r_slot_x[j+1];
                                    n_slot_y[j]  = r_slot_y[j+1];
                                end
                            end
                            cnt = r_count - CW'(1);
                        end
                        n_count = cnt;
                        dt = r_t - r_tbegin;
                        if (dt <= 32'(r_tap_ms)) begin
                            dt = r_t - r_tfinish;
                            if (r_mode == M_WDOUBLE && dt > 32'(r_tap_ms)) begin
                                n_darm   = 1'b0;
                                n_res[k] = make_res(K_TAP_OK, r_t, r_x, r_y, '0, '0, 1'b0);
                                k        = k + 2'd1;
                                n_mode   = M_WSINGLE;
                            end
                            if (n_mode == M_WDOUBLE) begin
                                n_darm   = 1'b0;
                                n_res[k] = make_res(K_DOUBLE, r_t, r_x, r_y, '0, '0, 1'b0);
                                k        = k + 2'd1;
                                n_mode   = M_NONE;
                            end else if (n_mode == M_WSINGLE) begin
                                n_larm   = 1'b0;
                                n_res[k] = make_res(K_TAP_UP, r_t, r_x, r_y, '0, '0, 1'b0);
                                k        = k + 2'd1;
                                n_mode   = M_WDOUBLE;
                                n_ddl    = r_t + 32'(r_tap_ms);
                                n_darm   = 1'b1;
                            end
                            n_tfinish = r_t;
                        end
                        if (n_mode == M_WSINGLE) n_mode = M_NONE;
                        if (cnt == '0) n_accum = '0;
                    end
                    default: begin
                        if (r_mode == M_PINCH) begin
                            if (r_count != '0) begin
                                n_res[k] = make_res(K_P_END, r_t, r_slot_x[0], r_slot_y[0],
                                                    SPAN_W'(1), SPAN_W'(1), 1'b1);
                            end else begin
                                n_res[k] = make_res(K_P_END, r_t, r_x, r_y,
                                                    SPAN_W'(1), SPAN_W'(1), 1'b1);
                            end
                            k      = k + 2'd1;
                            n_mode = M_NONE;
                        end
                        n_count = '0;
                    end
                endcase
                n_state = S_PSET;
            end
            S_PSET: begin
                if (r_count > CW'(1)) begin
                    n_dx    = $signed({r_slot_x[0][15], r_slot_x[0]}) - $signed({lx[15], lx});
                    n_dy    = $signed({r_slot_y[0][15], r_slot_y[0]}) - $signed({ly[15], ly});
                    s       = $signed({r_slot_x[0][15], r_slot_x[0]}) + $signed({lx[15], lx});
                    s       = s + $signed({16'd0, s[16]});
                    n_fx    = s[16:1];
                    s       = $signed({r_slot_y[0][15], r_slot_y[0]}) + $signed({ly[15], ly});
                    s       = s + $signed({16'd0, s[16]});
                    n_fy    = s[16:1];
                    n_phase = 1'b1;
                    n_state = S_MULX;
                end else begin
                    if (r_mode == M_PINCH) begin
                        if (r_count != '0) begin
                            n_res[k] = make_res(K_P_END, r_t, r_slot_x[0], r_slot_y[0],
                                                SPAN_W'(1), SPAN_W'(1), 1'b1);
                        end else begin
                            n_res[k] = make_res(K_P_END, r_t, r_rx, r_ry,
                                                SPAN_W'(1), SPAN_W'(1), 1'b1);
                        end
                        k      = k + 2'd1;
                        n_mode = M_NONE;
                    end
                    n_state = (k != 2'd0) ? S_OUT : S_IDLE;
                end
            end
            S_PINCH: begin
                n_sprev = r_sprev;
                if (r_mode == M_NONE) begin
                    n_sprev = w_root;
                    n_mode  = M_WPINCH;
                end
                if (n_mode == M_WPINCH) begin
                    d   = (w_root > n_sprev) ? w_root - n_sprev : n_sprev - w_root;
                    sum = (ACCUM_W+1)'(r_accum) + (ACCUM_W+1)'(d);
                    n_accum = sum[ACCUM_W] ? {ACCUM_W{1'b1}} : sum[ACCUM_W-1:0];
                    if (n_accum > ACCUM_W'(r_pinch_px)) begin
                        n_res[k] = make_res(K_P_START, r_t, r_fx, r_fy, w_root, w_root, 1'b1);
                        k        = k + 2'd1;
                        n_mode   = M_PINCH;
                        shown    = 1'b1;
                    end
                end else if (n_mode == M_PINCH) begin
                    n_res[k] = make_res(K_P_SCALE, r_t, r_fx, r_fy, w_root, r_sprev, 1'b1);
                    k        = k + 2'd1;
                    shown    = 1'b1;
                end
                n_sprev = w_root;
                if (!shown) begin
                    n_res[k] = make_res(K_NONE, '0, '0, '0, '0, '0, 1'b1);
                    k        = k + 2'd1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_m_axis_tready) begin
                    n_oidx = r_oidx + 2'd1;
                    if (r_oidx == r_nres - 2'd1) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state != S_IDLE && r_state != S_OUT) n_nres = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_mode     <= M_NONE;
            r_accum    <= '0;
            r_sprev    <= '0;
            r_tbegin   <= '0;
            r_tfinish  <= '0;
            r_spx      <= '0;
            r_spy      <= '0;
            r_ldl      <= '0;
            r_larm     <= 1'b0;
            r_ddl      <= '0;
            r_darm     <= 1'b0;
            r_rx       <= '0;
            r_ry       <= '0;
            r_rt       <= '0;
            r_nres     <= '0;
            r_oidx     <= '0;
            r_long_ms  <= RST_LONG_MS;
            r_tap_ms   <= RST_TAP_MS;
            r_move_px  <= RST_MOVE_PX;
            r_pinch_px <= RST_PINCH_PX;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_mode    <= n_mode;
            r_accum   <= n_accum;
            r_sprev   <= n_sprev;
            r_tbegin  <= n_tbegin;
            r_tfinish <= n_tfinish;
            r_spx     <= n_spx;
            r_spy     <= n_spy;
            r_ldl     <= n_ldl;
            r_larm    <= n_larm;
            r_ddl     <= n_ddl;
            r_darm    <= n_darm;
            r_rx      <= n_rx;
            r_ry      <= n_ry;
            r_rt      <= n_rt;
            r_nres    <= n_nres;
            r_oidx    <= n_oidx;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_LONG_MS:  r_long_ms  <= i_cfg_data;
                    CFG_TAP_MS:   r_tap_ms   <= i_cfg_data;
                    CFG_MOVE_PX:  r_move_px  <= i_cfg_data[11:0];
                    CFG_PINCH_PX: r_pinch_px <= i_cfg_data[11:0];
                    default:      r_long_ms  <= r_long_ms;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot_id <= n_slot_id;
        r_slot_x  <= n_slot_x;
        r_slot_y  <= n_slot_y;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_fx      <= n_fx;
        r_fy      <= n_fy;
        r_acc     <= n_acc;
        r_phase   <= n_phase;
        r_res     <= n_res;
        if (w_in_acc) begin
            r_op <= i_s_axis_tdata[2:0];
            r_id <= w_in_id;
            r_x  <= i_s_axis_tdata[26:11];
            r_y  <= i_s_axis_tdata[42:27];
            r_t  <= i_s_axis_tdata[74:43];
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT);
    assign o_m_axis_tdata  = {{(OUT_W - $bits(t_res)){1'b0}}, r_res[r_oidx]};
    assign o_m_axis_tlast  = (r_oidx == r_nres - 2'd1);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("event accepted while results are pending");

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_nres != 2'd0 && r_oidx < r_nres))
        else $error("result beat offered from an empty buffer");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_m_axis_tlast) |=> o_s_axis_tready)
        else $error("block not idle after the final result beat");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TOUCHES))
        else $error("touch table overfilled");

endmodule

@@ tb/tb_touch_gesture_recognizer_top.sv @@
// Self-checking testbench for the touch gesture recogniser: directed and random streams checked against a predictor.
module tb_touch_gesture_recognizer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tgr_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] t;
    } touch_evt_t;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] etime;
        logic [15:0] px;
        logic [15:0] py;
        logic [16:0] sn;
        logic [16:0] sb;
        logic        cons;
        logic        last;
    } gesture_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     o_m_axis_tdata;
    logic                 o_m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = CFG_LONG_MS;
    logic [15:0]          i_cfg_data = '0;

    touch_gesture_recognizer_top DUT (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state.
    logic [15:0] long_ms = RST_LONG_MS, tap_ms = RST_TAP_MS;
    logic [11:0] move_px = RST_MOVE_PX, pinch_px = RST_PINCH_PX;
    logic [7:0]  tbl_id [8];
    int          tbl_x [8], tbl_y [8];
    int          tbl_n = 0;
    t_mode       gmode = M_NONE;
    logic [17:0] accum = '0;
    logic [16:0] prev_span = '0;
    logic [31:0] begin_ms = '0, finish_ms = '0, long_dl = '0, dbl_dl = '0;
    logic [31:0] seen_t = '0;
    int          org_x = 0, org_y = 0, seen_x = 0, seen_y = 0;
    bit          long_on = 0, dbl_on = 0;

    gesture_t    gestures_due [$];
    touch_evt_t  pend [$];
    touch_evt_t  cur;
    int          n_emit, errors = 0, src_gap = 0, snk_gap = 0;
    bit          calm = 0, hold = 0;
    logic [31:0] now_ms = 32'hFFFF_F000;

    function automatic logic [16:0] root_floor(longint unsigned v);
        longint unsigned r = 0, b = 64'h1 << 40;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r[16:0];
    endfunction

    function automatic bit deadline_hit(logic [31:0] t, logic [31:0] dl);
        logic [31:0] d = t - dl;
        return d[31] == 1'b0;
    endfunction

    task automatic add_gesture(logic [2:0] k, logic [31:0] t, int x, int y,
                               logic [16:0] sn, logic [16:0] sb, logic c);
        gesture_t g;
        if (n_emit >= RES_MAX) return;
        g.kind = k; g.etime = t; g.px = x[15:0]; g.py = y[15:0];
        g.sn = sn; g.sb = sb; g.cons = c; g.last = 0;
        gestures_due.push_back(g);
        n_emit++;
    endtask

    task automatic drop_tap();
        begin_ms = 0;
        if (gmode == M_WSINGLE) begin
            long_on = 0;
            gmode = M_NONE;
        end else if (gmode == M_WDOUBLE) begin
            gmode = M_NONE;
        end
    endtask

    task automatic end_pinch(logic [31:0] t);
        if (tbl_n > 0) add_gesture(K_P_END, t, tbl_x[0], tbl_y[0], 1, 1, 1);
        else add_gesture(K_P_END, t, seen_x, seen_y, 1, 1, 1);
        gmode = M_NONE;
    endtask

    task automatic track_pinch(logic [31:0] t);
        int          fx, fy;
        longint      dx, dy;
        logic [16:0] span, d;
        logic [18:0] sum;
        bit          shown = 0;
        if (tbl_n > 1) begin
            fx = (tbl_x[0] + tbl_x[tbl_n-1]) / 2;
            fy = (tbl_y[0] + tbl_y[tbl_n-1]) / 2;
            dx = tbl_x[0] - tbl_x[tbl_n-1];
            dy = tbl_y[0] - tbl_y[tbl_n-1];
            span = root_floor(dx * dx + dy * dy);
            if (gmode == M_NONE) begin
                prev_span = span;
                gmode = M_WPINCH;
            end
            if (gmode == M_WPINCH) begin
                d = span > prev_span ? span - prev_span : prev_span - span;
                sum = accum + d;
                accum = sum > 19'h3FFFF ? 18'h3FFFF : sum[17:0];
                if (accum > pinch_px) begin
                    add_gesture(K_P_START, t, fx, fy, span, span, 1);
                    gmode = M_PINCH;
                    shown = 1;
                end
            end else if (gmode == M_PINCH) begin
                add_gesture(K_P_SCALE, t, fx, fy, span, prev_span, 1);
                shown = 1;
            end
            prev_span = span;
            if (!shown) add_gesture(K_NONE, 0, 0, 0, 0, 0, 1);
        end else if (gmode == M_PINCH) begin
            end_pinch(t);
        end
    endtask

    task automatic predict_gestures(touch_evt_t e);
        int     x = $signed(e.x), y = $signed(e.y);
        longint dx, dy;
        bit     found = 0;
        n_emit = 0;
        if (e.op > OP_TICK) return;
        if (e.op == OP_TICK) begin
            if (long_on && deadline_hit(e.t, long_dl)) begin
                long_on = 0;
                if (gmode == M_WSINGLE) begin
                    gmode = M_NONE;
                    add_gesture(K_LONG, seen_t, seen_x, seen_y, 0, 0, 0);
                end
            end
            if (dbl_on && deadline_hit(e.t, dbl_dl)) begin
                dbl_on = 0;
                if (gmode == M_WDOUBLE) begin
                    gmode = M_NONE;
                    add_gesture(K_TAP_OK, seen_t, seen_x, seen_y, 0, 0, 0);
                end
            end
        end else begin
            seen_x = x; seen_y = y; seen_t = e.t;
            case (e.op)
                OP_DOWN: begin
                    for (int i = 0; i < tbl_n; i++) if (tbl_id[i] == e.id) found = 1;
                    if (!found && tbl_n < 8) begin
                        tbl_id[tbl_n] = e.id; tbl_x[tbl_n] = x; tbl_y[tbl_n] = y;
                        tbl_n++;
                    end
                    if (tbl_n == 1) begin
                        begin_ms = e.t; org_x = x; org_y = y;
                        if (gmode == M_NONE) begin
                            gmode = M_WSINGLE;
                            long_dl = e.t + long_ms;
                            long_on = 1;
                        end
                    end else if (tbl_n == 2) begin
                        drop_tap();
                    end
                end
                OP_MOVE: begin
                    dx = org_x - x;
                    dy = org_y - y;
                    if (tbl_n == 1 && dx * dx + dy * dy > longint'(move_px) * move_px)
                        drop_tap();
                    for (int i = 0; i < tbl_n; i++)
                        if (tbl_id[i] == e.id) begin
                            tbl_x[i] = x; tbl_y[i] = y;
                        end
                end
                OP_UP: begin
                    for (int i = 0; i < tbl_n; i++)
                        if (tbl_id[i] == e.id) begin
                            for (int j = i; j + 1 < tbl_n; j++) begin
                                tbl_id[j] = tbl_id[j+1]; tbl_x[j] = tbl_x[j+1];
                                tbl_y[j] = tbl_y[j+1];
                            end
                            tbl_n--;
                            break;
                        end
                    if (e.t - begin_ms <= {16'd0, tap_ms}) begin
                        if (gmode == M_WDOUBLE && e.t - finish_ms > {16'd0, tap_ms}) begin
                            dbl_on = 0;
                            add_gesture(K_TAP_OK, seen_t, seen_x, seen_y, 0, 0, 0);
                            gmode = M_WSINGLE;
                        end
                        if (gmode == M_WDOUBLE) begin
                            dbl_on = 0;
                            add_gesture(K_DOUBLE, e.t, x, y, 0, 0, 0);
                            gmode = M_NONE;
                        end else if (gmode == M_WSINGLE) begin
                            long_on = 0;
                            add_gesture(K_TAP_UP, e.t, x, y, 0, 0, 0);
                            gmode = M_WDOUBLE;
                            dbl_dl = e.t + tap_ms;
                            dbl_on = 1;
                        end
                        finish_ms = e.t;
                    end
                    if (gmode == M_WSINGLE) gmode = M_NONE;
                    if (tbl_n == 0) accum = 0;
                end
                default: begin
                    if (gmode == M_PINCH) end_pinch(e.t);
                    tbl_n = 0;
                end
            endcase
            track_pinch(e.t);
        end
        if (n_emit > 0) gestures_due[$].last = 1;
    endtask

    // Sender: one beat in flight, random bursts of idling between beats.
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            busy = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_gestures(cur);
                busy = 0;
            end
            if (!busy) begin
                if (src_gap > 0) src_gap--;
                else if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 18);
                if (src_gap == 0 && !hold && pend.size() > 0) begin
                    cur = pend.pop_front();
                    i_s_axis_tdata <= {5'd0, cur.t, cur.y, cur.x, cur.id, cur.op};
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, and each result beat checked against the oldest expectation.
    always @(posedge i_clk) begin
        gesture_t g;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (gestures_due.size() == 0) begin
                    $error("unexpected result beat %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    g = gestures_due.pop_front();
                    if (o_m_axis_tdata[2:0] !== g.kind) begin
                        $error("gesture_kind exp %0d got %0d", g.kind, o_m_axis_tdata[2:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[34:3] !== g.etime) begin
                        $error("event_time exp %0d got %0d", g.etime, o_m_axis_tdata[34:3]);
                        errors++;
                    end
                    if (o_m_axis_tdata[50:35] !== g.px) begin
                        $error("point_x exp %0d got %0d", $signed(g.px),
                               $signed(o_m_axis_tdata[50:35]));
                        errors++;
                    end
                    if (o_m_axis_tdata[66:51] !== g.py) begin
                        $error("point_y exp %0d got %0d", $signed(g.py),
                               $signed(o_m_axis_tdata[66:51]));
                        errors++;
                    end
                    if (o_m_axis_tdata[83:67] !== g.sn) begin
                        $error("span_now exp %0d got %0d", g.sn, o_m_axis_tdata[83:67]);
                        errors++;
                    end
                    if (o_m_axis_tdata[100:84] !== g.sb) begin
                        $error("span_before exp %0d got %0d", g.sb, o_m_axis_tdata[100:84]);
                        errors++;
                    end
                    if (o_m_axis_tdata[101] !== g.cons) begin
                        $error("consumed exp %0d got %0d", g.cons, o_m_axis_tdata[101]);
                        errors++;
                    end
                    if (o_m_axis_tlast !== g.last) begin
                        $error("last exp %0d got %0d", g.last, o_m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (snk_gap > 0) snk_gap--;
            else if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 18);
            i_m_axis_tready <= (snk_gap == 0);
        end
    end

    task automatic put(int op, int id, int x, int y, int unsigned step);
        touch_evt_t e;
        now_ms += step;
        e.op = op[2:0]; e.id = id[7:0]; e.x = x[15:0]; e.y = y[15:0]; e.t = now_ms;
        pend.push_back(e);
    endtask

    task automatic settle();
        while (pend.size() > 0 || i_s_axis_tvalid || gestures_due.size() > 0) @(negedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_LONG_MS:  long_ms = v;
            CFG_TAP_MS:   tap_ms = v;
            CFG_MOVE_PX:  move_px = v[11:0];
            default:      pinch_px = v[11:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [15:0] lm, logic [15:0] tm, logic [15:0] mp, logic [15:0] pp);
        settle();
        set_reg(CFG_LONG_MS, lm);
        set_reg(CFG_TAP_MS, tm);
        set_reg(CFG_MOVE_PX, mp);
        set_reg(CFG_PINCH_PX, pp);
    endtask

    function automatic int coord();
        if ($urandom_range(0, 9) == 0) return $signed(16'($urandom()));
        return $urandom_range(0, 400) - 200;
    endfunction

    task automatic random_gestures(int n);
        int          a, b, x, y, k;
        int unsigned reach = tap_ms + 40;
        while (n > 0) begin
            a = $urandom_range(0, 255);
            b = a ^ (1 << $urandom_range(0, 7));
            x = coord(); y = coord();
            case ($urandom_range(0, 5))
                0, 1: begin
                    put(OP_DOWN, a, x, y, $urandom_range(0, 800));
                    if ($urandom_range(0, 1)) put(OP_MOVE, a, x + $urandom_range(0, 60) - 30, y,
                                                  $urandom_range(0, 50));
                    put(OP_UP, a, x, y, $urandom_range(0, reach));
                    if ($urandom_range(0, 1)) put(OP_TICK, $urandom(), 0, 0,
                                                  $urandom_range(0, 2 * reach));
                    n -= 4;
                end
                2: begin
                    put(OP_DOWN, a, x, y, $urandom_range(0, 800));
                    put(OP_TICK, $urandom(), coord(), coord(), $urandom_range(0, long_ms + 100));
                    put(OP_TICK, $urandom(), coord(), coord(), $urandom_range(0, 300));
                    put(OP_UP, a, x, y, $urandom_range(0, 100));
                    n -= 4;
                end
                3, 4: begin
                    put(OP_DOWN, a, x, y, $urandom_range(0, 300));
                    put(OP_DOWN, b, x + $urandom_range(0, 80), y, $urandom_range(0, 30));
                    if ($urandom_range(0, 3) == 0) put(OP_DOWN, a + 1, coord(), coord(), 5);
                    k = $urandom_range(2, 7);
                    repeat (k) begin
                        x += $urandom_range(0, 60) - 20;
                        put(OP_MOVE, $urandom_range(0, 1) ? b : a, x, y + $urandom_range(0, 9),
                            $urandom_range(0, 20));
                    end
                    if ($urandom_range(0, 3) == 0) put(OP_CANCEL, a, x, y, 10);
                    else begin
                        put(OP_UP, b, x, y, $urandom_range(0, 40));
                        put(OP_UP, a, x, y, $urandom_range(0, 40));
                        put(OP_UP, a + 1, x, y, 3);
                    end
                    n -= k + 5;
                end
                default: begin
                    put($urandom_range(0, 7), $urandom(), $signed(16'($urandom())),
                        $signed(16'($urandom())), $urandom_range(0, 1) ? $urandom() : 100);
                    n--;
                end
            endcase
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Tap, confirmed tap, long tap and double tap.
        put(OP_DOWN, 8'h01, 100, 200, 10);
        put(OP_UP, 8'h01, 101, 201, 50);
        put(OP_TICK, 8'hFF, 0, 0, 400);
        put(OP_DOWN, 8'h02, -32768, 32767, 100);
        put(OP_TICK, 8'h00, 0, 0, 600);
        put(OP_UP, 8'h02, 0, 0, 10);
        put(OP_DOWN, 8'h03, 5, 5, 1000);
        put(OP_UP, 8'h03, 5, 5, 40);
        put(OP_DOWN, 8'h03, 6, 6, 60);
        put(OP_UP, 8'h03, 6, 6, 40);
        // Pinch at the coordinate extremes, duplicate down, unknown id, cancel mid pinch, table overflow, bad ops.
        put(OP_DOWN, 8'hAA, -32768, -32768, 500);
        put(OP_DOWN, 8'hAA, 0, 0, 1);
        put(OP_DOWN, 8'h55, 32767, 32767, 1);
        put(OP_MOVE, 8'h55, 0, 0, 1);
        put(OP_MOVE, 8'h55, 32767, -32768, 1);
        put(OP_UP, 8'h77, 1, 1, 1);
        put(OP_CANCEL, 8'h00, 3, 4, 1);
        put(OP_UP, 8'hAA, 0, 0, 1);
        for (int i = 0; i < 9; i++) put(OP_DOWN, i, i * 10, -i * 10, 2);
        put(5, 8'hFF, -1, -1, 1);
        put(6, 8'h00, 0, 0, 1);
        put(7, 8'h80, 1, 1, 1);
        put(OP_CANCEL, 8'h00, 0, 0, 1);
        put(OP_UP, 8'h00, 0, 0, 1);
        // Hold the remaining beats back until everything sent so far has drained.
        while (pend.size() > 8) @(negedge i_clk);
        hold = 1;
        while (gestures_due.size() > 0 || i_s_axis_tvalid) @(negedge i_clk);
        repeat (60) @(posedge i_clk);
        hold = 0;
        random_gestures(60);
        set_all(16'd0, 16'd0, 16'd0, 16'd0);
        random_gestures(40);
        set_all(16'hFFFF, 16'hFFFF, 16'hFFF, 16'hFFF);
        random_gestures(40);
        set_all(16'd200, 16'd150, 16'd20, 16'd30);
        random_gestures(60);
        calm = 1;
        random_gestures(50);
        while (pend.size() > 0 || i_s_axis_tvalid || gestures_due.size() > 0) @(negedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("touch_gesture_recognizer_top verification clean");
        else $display("touch_gesture_recognizer_top verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("touch_gesture_recognizer_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tgr_pkg.sv
sv/tgr_isqrt.sv
sv/touch_gesture_recognizer_top.sv
tb/tb_touch_gesture_recognizer_top.sv
